### hw/rtl/h20sg_pkg.sv
package h20sg_pkg;

  localparam int FracBits  = 16;
  localparam int CoordW    = 18;
  localparam int OutW      = 20;
  localparam int AccW      = 32;
  localparam int ProdW     = AccW + CoordW;
  localparam int NodeCount = 20;
  localparam int NodeW     = 5;
  localparam int CoefW     = 8;
  // floor(n / 5) = (n * RecipFive) >> RecipShift, exact for n below 2^27
  localparam int RecipShift = 29;
  localparam logic [26:0] RecipFive = 27'd107374183;
  localparam int QuotW = 24;
  localparam logic [NodeW-1:0] LastNode = NodeW'(NodeCount - 1);

  // Horner phase codes: three t-steps, then s-step, then r-step
  localparam logic [2:0] PhT0 = 3'd0;
  localparam logic [2:0] PhT1 = 3'd1;
  localparam logic [2:0] PhT2 = 3'd2;
  localparam logic [2:0] PhS  = 3'd3;
  localparam logic [2:0] PhR  = 3'd4;

  // polynomial kinds, one per lane
  localparam logic [1:0] KindVal = 2'd0;
  localparam logic [1:0] KindDr  = 2'd1;
  localparam logic [1:0] KindDs  = 2'd2;
  localparam logic [1:0] KindDt  = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] r;
    logic signed [CoordW-1:0] s;
    logic signed [CoordW-1:0] t;
  } coord_t;

  typedef struct packed {
    logic       step;
    logic [2:0] phase;
    logic       first_b;
    logic       first_a;
    logic       fin1;
    logic       fin2;
  } lane_ctl_t;

  localparam int NodeX [NodeCount] = '{-1, 1, 1,-1,-1, 1, 1,-1, 0,-1,-1, 1, 1, 0, 1,-1, 0,-1, 1, 0};
  localparam int NodeY [NodeCount] = '{-1,-1, 1, 1,-1,-1, 1, 1,-1, 0,-1, 0,-1, 1, 1, 1,-1, 0, 0, 1};
  localparam int NodeZ [NodeCount] = '{-1,-1,-1,-1, 1, 1, 1, 1,-1,-1, 0,-1, 0,-1, 0, 0, 1, 1, 1, 1};

  function automatic int base_coef(int n, int p0, int p1, int p2);
    int x, y, z, d, dv, dw, pu, pv, pw, p, q, c;
    int pos [3];
    int pp [3];
    x = NodeX[n];
    y = NodeY[n];
    z = NodeZ[n];
    pos[0] = x; pos[1] = y; pos[2] = z;
    pp[0] = p0; pp[1] = p1; pp[2] = p2;
    c = 0;
    if (x != 0 && y != 0 && z != 0) begin
      if (p0 == 2 && p1 == 2 && p2 == 2) c = 9;
      if (p0 == 2 && p1 == 2 && p2 == 1) c = 5 * z;
      if (p0 == 2 && p1 == 1 && p2 == 2) c = 5 * y;
      if (p0 == 1 && p1 == 2 && p2 == 2) c = 5 * x;
      if (p0 == 2 && p1 == 1 && p2 == 1) c = 5 * y * z;
      if (p0 == 1 && p1 == 2 && p2 == 1) c = 5 * x * z;
      if (p0 == 1 && p1 == 1 && p2 == 2) c = 5 * x * y;
      if (p0 == 1 && p1 == 1 && p2 == 1) c = 5 * x * y * z;
      if (p0 == 2 && p1 == 2 && p2 == 0) c = -2;
      if (p0 == 2 && p1 == 0 && p2 == 2) c = -2;
      if (p0 == 0 && p1 == 2 && p2 == 2) c = -2;
      if (p0 == 0 && p1 == 0 && p2 == 0) c = 2;
    end else begin
      d  = (x == 0) ? 0 : ((y == 0) ? 1 : 2);
      dv = (d == 0) ? 1 : 0;
      dw = (d == 2) ? 1 : 2;
      p  = pos[dv];
      q  = pos[dw];
      pu = pp[d];
      pv = pp[dv];
      pw = pp[dw];
      if (pu == 2 && pv == 2 && pw == 2) c = -6;
      if (pu == 2 && pv == 2 && pw == 1) c = -10 * q;
      if (pu == 2 && pv == 1 && pw == 2) c = -10 * p;
      if (pu == 2 && pv == 1 && pw == 1) c = -10 * p * q;
      if (pu == 2 && pv == 2 && pw == 0) c = -2;
      if (pu == 2 && pv == 0 && pw == 2) c = -2;
      if (pu == 0 && pv == 2 && pw == 2) c = 8;
      if (pu == 0 && pv == 2 && pw == 1) c = 10 * q;
      if (pu == 0 && pv == 1 && pw == 2) c = 10 * p;
      if (pu == 0 && pv == 1 && pw == 1) c = 10 * p * q;
      if (pu == 0 && pv == 0 && pw == 0) c = 2;
    end
    return c;
  endfunction

  // coefficient of r^pa s^pb t^pe in the numerator of one polynomial kind
  function automatic logic signed [CoefW-1:0] poly_coef(logic [NodeW-1:0] node,
                                                        logic [1:0] kind, logic [1:0] pa,
                                                        logic [1:0] pb, logic [1:0] pe);
    int pw [3];
    int axis, k, v;
    pw[0] = int'(pa); pw[1] = int'(pb); pw[2] = int'(pe);
    v = 0;
    if (kind == KindVal) begin
      v = base_coef(int'(node), pw[0], pw[1], pw[2]);
    end else begin
      axis = int'(kind) - 1;
      if (pw[axis] < 2) begin
        k = pw[axis] + 1;
        pw[axis] = k;
        v = k * base_coef(int'(node), pw[0], pw[1], pw[2]);
      end
    end
    return CoefW'(v);
  endfunction

endpackage

### hw/rtl/h20sg_front.sv
module h20sg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  h20sg_pkg::coord_t in_data_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output h20sg_pkg::coord_t pop_data_o,
  output logic [1:0]      fill_o
);
  import h20sg_pkg::*;

  coord_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = pop_i && (cnt_q != 2'd0);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign fill_o      = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

endmodule

### hw/rtl/h20sg_lane.sv
module h20sg_lane (
  input  logic                                     clk_i,
  input  h20sg_pkg::lane_ctl_t                     ctl_i,
  input  logic signed [h20sg_pkg::CoordW-1:0]      x_i,
  input  logic signed [h20sg_pkg::CoefW-1:0]       coef_i,
  output logic signed [h20sg_pkg::OutW-1:0]        result_o
);
  import h20sg_pkg::*;

  logic signed [AccW-1:0]  acc_t_q, acc_s_q, acc_r_q;
  logic signed [AccW-1:0]  op, addend, sum;
  logic signed [ProdW-1:0] prod, wrnd, shifted;
  logic        [AccW-1:0]  absv;
  logic        [26:0]      n_q;
  logic                    neg_q;
  logic        [53:0]      qprod;
  logic        [QuotW-1:0] quo_q;

  always_comb begin
    op     = '0;
    addend = '0;
    if (ctl_i.phase == PhS) begin
      op     = ctl_i.first_b ? '0 : acc_s_q;
      addend = acc_t_q;
    end else if (ctl_i.phase == PhR) begin
      op     = ctl_i.first_a ? '0 : acc_r_q;
      addend = acc_s_q;
    end else begin
      op     = (ctl_i.phase == PhT0) ? '0 : acc_t_q;
      addend = AccW'(coef_i) <<< FracBits;
    end
    prod    = op * x_i;
    // round half up: add half an lsb, then floor
    wrnd    = prod + (ProdW'(1) <<< (FracBits - 1));
    shifted = wrnd >>> FracBits;
    sum     = shifted[AccW-1:0] + addend;
    absv    = acc_r_q[AccW-1] ? AccW'(-acc_r_q) : AccW'(acc_r_q);
    qprod   = 54'(n_q) * 54'(RecipFive);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      if (ctl_i.phase == PhS) acc_s_q <= sum;
      else if (ctl_i.phase == PhR) acc_r_q <= sum;
      else acc_t_q <= sum;
    end
    if (ctl_i.fin1) begin
      n_q   <= 27'((absv + AccW'(20)) >> 3);
      neg_q <= acc_r_q[AccW-1];
    end
    if (ctl_i.fin2) quo_q <= qprod[RecipShift +: QuotW];
  end

  always_comb begin
    if (neg_q) begin
      if (quo_q > QuotW'(524288)) result_o = OutW'(-524288);
      else result_o = OutW'(-$signed({1'b0, quo_q}));
    end else begin
      if (quo_q > QuotW'(524287)) result_o = OutW'(524287);
      else result_o = OutW'(quo_q);
    end
  end

endmodule

### hw/rtl/h20sg_back.sv
module h20sg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_o,
  input  h20sg_pkg::coord_t                   pop_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [h20sg_pkg::NodeW-1:0]         node_index_o,
  output logic signed [h20sg_pkg::OutW-1:0]   shape_value_o,
  output logic signed [h20sg_pkg::OutW-1:0]   grad_r_o,
  output logic signed [h20sg_pkg::OutW-1:0]   grad_s_o,
  output logic signed [h20sg_pkg::OutW-1:0]   grad_t_o,
  output logic                                last_node_o
);
  import h20sg_pkg::*;

  typedef enum logic [4:0] {
    SIdle = 5'b00001,
    SRun  = 5'b00010,
    SFin1 = 5'b00100,
    SFin2 = 5'b01000,
    SOut  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  coord_t           pt_q;
  logic [NodeW-1:0] node_q;
  logic [1:0]       a_q, b_q;
  logic [2:0]       ph_q;
  logic             load, out_free, node_done;
  lane_ctl_t        ctl;
  logic signed [CoordW-1:0] x_sel;
  logic [1:0]       pe;
  logic signed [OutW-1:0] res [4];
  logic signed [CoefW-1:0] coef [4];

  assign out_free  = !out_valid_o || !out_stall_i;
  assign node_done = (ph_q == PhR) && (a_q == 2'd0);

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    unique case (state_q)
      SIdle: if (pop_valid_i) begin
        load    = 1'b1;
        state_d = SRun;
      end
      SRun:  if (node_done) state_d = SFin1;
      SFin1: state_d = SFin2;
      SFin2: state_d = SOut;
      SOut:  if (out_free) begin
        if (node_q != LastNode) state_d = SRun;
        else if (pop_valid_i) begin
          load    = 1'b1;
          state_d = SRun;
        end else state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign pop_o = load;

  always_comb begin
    ctl.step    = (state_q == SRun);
    ctl.phase   = ph_q;
    ctl.first_b = (b_q == 2'd2);
    ctl.first_a = (a_q == 2'd2);
    ctl.fin1    = (state_q == SFin1);
    ctl.fin2    = (state_q == SFin2);
    if (ph_q == PhS) x_sel = pt_q.s;
    else if (ph_q == PhR) x_sel = pt_q.r;
    else x_sel = pt_q.t;
    pe = 2'd2 - ph_q[1:0];
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign coef[k] = poly_coef(node_q, 2'(k), a_q, b_q, pe);
    h20sg_lane u_lane (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .x_i      (x_sel),
      .coef_i   (coef[k]),
      .result_o (res[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      node_q      <= '0;
      a_q         <= 2'd2;
      b_q         <= 2'd2;
      ph_q        <= PhT0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SRun) begin
        if (ph_q == PhT0 || ph_q == PhT1) ph_q <= ph_q + 3'd1;
        else if (ph_q == PhT2) ph_q <= PhS;
        else if (ph_q == PhS) begin
          if (b_q != 2'd0) begin
            b_q  <= b_q - 2'd1;
            ph_q <= PhT0;
          end else ph_q <= PhR;
        end else begin
          a_q  <= (a_q != 2'd0) ? a_q - 2'd1 : 2'd2;
          b_q  <= 2'd2;
          ph_q <= PhT0;
        end
      end
      if (state_q == SOut && out_free) begin
        out_valid_o <= 1'b1;
        node_q      <= (node_q == LastNode) ? '0 : node_q + NodeW'(1);
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) pt_q <= pop_data_i;
    if (state_q == SOut && out_free) begin
      node_index_o  <= node_q;
      shape_value_o <= res[0];
      grad_r_o      <= res[1];
      grad_s_o      <= res[2];
      grad_t_o      <= res[3];
      last_node_o   <= (node_q == LastNode);
    end
  end

endmodule

### hw/rtl/hex20_shape_and_gradient.sv
// Flow: an accepted item is loaded, then each node runs 39 Horner multiply steps on the
// shared lane multipliers, two divide steps and an output step.
// Results: 20 per item, one per node, held while the receiver stalls; the
// four lanes evaluate value and gradients of a node together.
// A two-item input queue takes new points while the engine works.
// Reset: asynchronous, active low; clears queue, sequencer and output valid.
module hex20_shape_and_gradient (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [h20sg_pkg::CoordW-1:0] coord_r_i,
  input  logic signed [h20sg_pkg::CoordW-1:0] coord_s_i,
  input  logic signed [h20sg_pkg::CoordW-1:0] coord_t_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [h20sg_pkg::NodeW-1:0]         node_index_o,
  output logic signed [h20sg_pkg::OutW-1:0]   shape_value_o,
  output logic signed [h20sg_pkg::OutW-1:0]   grad_r_o,
  output logic signed [h20sg_pkg::OutW-1:0]   grad_s_o,
  output logic signed [h20sg_pkg::OutW-1:0]   grad_t_o,
  output logic                                last_node_o
);
  import h20sg_pkg::*;

  coord_t     in_data, pop_data;
  logic       pop_valid, pop;
  logic [1:0] fill;

  assign in_data.r = coord_r_i;
  assign in_data.s = coord_s_i;
  assign in_data.t = coord_t_i;

  h20sg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .fill_o      (fill)
  );

  h20sg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .pop_data_i    (pop_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .node_index_o  (node_index_o),
    .shape_value_o (shape_value_o),
    .grad_r_o      (grad_r_o),
    .grad_s_o      (grad_s_o),
    .grad_t_o      (grad_t_o),
    .last_node_o   (last_node_o)
  );

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_node_o == (node_index_o == LastNode)))
    else $error("last mark out of step with node index");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill != 2'd3)
    else $error("input queue over capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(node_index_o) && $stable(shape_value_o)))
    else $error("stalled result changed");

endmodule

### verif/hex20_shape_and_gradient_tb.sv
`timescale 1ns / 1ps

module hex20_shape_and_gradient_tb;
  import h20sg_pkg::*;

  localparam longint AccLimit = 64'sd1 << 40;
  localparam longint OutMax = 524287;
  localparam longint OutMin = -524288;
  localparam int HoldOffCycles = 4000;
  localparam int DrainCycles = 60;

  typedef struct {
    logic [NodeW-1:0] node;
    logic [OutW-1:0]  value;
    logic [OutW-1:0]  dr;
    logic [OutW-1:0]  ds;
    logic [OutW-1:0]  dt;
    logic             last;
  } node_result_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [CoordW-1:0] coord_r_i, coord_s_i, coord_t_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [NodeW-1:0] node_index_o;
  logic signed [OutW-1:0] shape_value_o, grad_r_o, grad_s_o, grad_t_o;
  logic last_node_o;

  node_result_t node_results_due[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  // node positions along r, s, t
  int pos_r [NodeCount] = '{-1, 1, 1,-1,-1, 1, 1,-1, 0,-1,-1, 1, 1, 0, 1,-1, 0,-1, 1, 0};
  int pos_s [NodeCount] = '{-1,-1, 1, 1,-1,-1, 1, 1,-1, 0,-1, 0,-1, 1, 1, 1,-1, 0, 0, 1};
  int pos_t [NodeCount] = '{-1,-1,-1,-1, 1, 1, 1, 1,-1,-1, 0,-1, 0,-1, 0, 0, 1, 1, 1, 1};

  hex20_shape_and_gradient DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("hex20_shape_and_gradient test failed");
    $finish;
  end

  // numerator coefficients over 40, index = pow_r*9 + pow_s*3 + pow_t
  function automatic void shape_coefs(int n, output int c [27]);
    int x, y, z, d, dv, dw, p, q;
    int pw [3];
    int sg [3];
    x = pos_r[n]; y = pos_s[n]; z = pos_t[n];
    sg[0] = x; sg[1] = y; sg[2] = z;
    for (int i = 0; i < 27; i++) c[i] = 0;
    if (x != 0 && y != 0 && z != 0) begin
      c[26] = 9;         c[25] = 5 * z;     c[23] = 5 * y;     c[17] = 5 * x;
      c[22] = 5 * y * z; c[16] = 5 * x * z; c[14] = 5 * x * y; c[13] = 5 * x * y * z;
      c[24] = -2;        c[20] = -2;        c[8] = -2;         c[0] = 2;
    end else begin
      d = (x == 0) ? 0 : ((y == 0) ? 1 : 2);
      dv = (d == 0) ? 1 : 0;
      dw = (d == 2) ? 1 : 2;
      p = sg[dv];
      q = sg[dw];
      for (int pu = 0; pu < 3; pu++)
        for (int pv = 0; pv < 3; pv++)
          for (int pwv = 0; pwv < 3; pwv++) begin
            int k;
            k = 0;
            if (pu == 2 && pv == 2 && pwv == 2) k = -6;
            if (pu == 2 && pv == 2 && pwv == 1) k = -10 * q;
            if (pu == 2 && pv == 1 && pwv == 2) k = -10 * p;
            if (pu == 2 && pv == 1 && pwv == 1) k = -10 * p * q;
            if (pu == 2 && pv == 2 && pwv == 0) k = -2;
            if (pu == 2 && pv == 0 && pwv == 2) k = -2;
            if (pu == 0 && pv == 2 && pwv == 2) k = 8;
            if (pu == 0 && pv == 2 && pwv == 1) k = 10 * q;
            if (pu == 0 && pv == 1 && pwv == 2) k = 10 * p;
            if (pu == 0 && pv == 1 && pwv == 1) k = 10 * p * q;
            if (pu == 0 && pv == 0 && pwv == 0) k = 2;
            pw[d] = pu; pw[dv] = pv; pw[dw] = pwv;
            if (k != 0) c[pw[0] * 9 + pw[1] * 3 + pw[2]] = k;
          end
    end
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > AccLimit) return AccLimit;
    if (v < -AccLimit) return -AccLimit;
    return v;
  endfunction

  // floor of (a*x + half) / 2^16 equals round to nearest, ties up
  function automatic longint scale_mul(longint a, longint x);
    return (a * x + (64'sd1 << (FracBits - 1))) >>> FracBits;
  endfunction

  function automatic logic [OutW-1:0] eval_over_40(int c [27], longint r, longint s,
                                                   longint t);
    longint acc_r, acc_s, acc_t, v, quo;
    acc_r = 0;
    for (int a = 2; a >= 0; a--) begin
      acc_s = 0;
      for (int b = 2; b >= 0; b--) begin
        acc_t = 0;
        for (int e = 2; e >= 0; e--)
          acc_t = clamp_acc(scale_mul(acc_t, t) + (longint'(c[a * 9 + b * 3 + e]) <<< FracBits));
        acc_s = clamp_acc(scale_mul(acc_s, s) + acc_t);
      end
      acc_r = clamp_acc(scale_mul(acc_r, r) + acc_s);
    end
    v = acc_r;
    quo = (v >= 0) ? (v + 20) / 40 : -((-v + 20) / 40);
    if (quo > OutMax) quo = OutMax;
    if (quo < OutMin) quo = OutMin;
    return quo[OutW-1:0];
  endfunction

  function automatic void predict_nodes(logic signed [CoordW-1:0] r, logic signed [CoordW-1:0] s,
                                        logic signed [CoordW-1:0] t);
    int c [27];
    int g [27];
    int pw [3];
    node_result_t res;
    for (int n = 0; n < NodeCount; n++) begin
      shape_coefs(n, c);
      res.node = n[NodeW-1:0];
      res.value = eval_over_40(c, r, s, t);
      for (int axis = 0; axis < 3; axis++) begin
        for (int i = 0; i < 27; i++) begin
          pw[0] = i / 9; pw[1] = (i / 3) % 3; pw[2] = i % 3;
          g[i] = 0;
          if (pw[axis] < 2) begin
            pw[axis]++;
            g[i] = pw[axis] * c[pw[0] * 9 + pw[1] * 3 + pw[2]];
          end
        end
        if (axis == 0) res.dr = eval_over_40(g, r, s, t);
        else if (axis == 1) res.ds = eval_over_40(g, r, s, t);
        else res.dt = eval_over_40(g, r, s, t);
      end
      res.last = (n == NodeCount - 1);
      node_results_due.push_back(res);
    end
  endfunction

  // receiver stall: random, or a requested long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      node_result_t e;
      if (node_results_due.size() == 0) begin
        $display("%0t: unexpected item node %0d", $time, node_index_o);
        errors++;
      end else begin
        e = node_results_due.pop_front();
        if (node_index_o !== e.node || shape_value_o !== e.value || grad_r_o !== e.dr ||
            grad_s_o !== e.ds || grad_t_o !== e.dt || last_node_o !== e.last) begin
          $display("%0t: mismatch expected node %0d val %0d dr %0d ds %0d dt %0d last %0b",
                   $time, e.node, $signed(e.value), $signed(e.dr), $signed(e.ds),
                   $signed(e.dt), e.last);
          $display("%0t:          actual node %0d val %0d dr %0d ds %0d dt %0d last %0b",
                   $time, node_index_o, shape_value_o, grad_r_o, grad_s_o, grad_t_o,
                   last_node_o);
          errors++;
        end
      end
    end
  end

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_point(logic signed [CoordW-1:0] r, logic signed [CoordW-1:0] s,
                            logic signed [CoordW-1:0] t);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    coord_r_i <= r;
    coord_s_i <= s;
    coord_t_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    predict_nodes(r, s, t);
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    if ($urandom_range(9) == 0) return CoordW'($urandom());
    return CoordW'(int'($urandom_range(131072)) - 65536);
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (node_results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_point(0, 0, 0);
    for (int n = 0; n < NodeCount; n += 2)
      send_point(CoordW'(pos_r[n] * 65536), CoordW'(pos_s[n] * 65536),
                 CoordW'(pos_t[n] * 65536));
    send_point(-65536, 65536, -65536);
    send_point(131071, 131071, 131071);
    send_point(-131072, -131072, -131072);
    send_point(131071, -131072, 1);
    send_point(-1, 32768, -32768);
    send_point(21845, -43690, 65535);
    wait_drained();
  endtask

  task automatic test_random(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    wait_drained();
  endtask

  // receiver holds off long enough for the input queue to fill
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_req = HoldOffCycles;
    for (int i = 0; i < 6; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    wait_drained();
  endtask

  // sender waits for every result before the next item
  task automatic test_paced();
    idle_pct = 0;
    stall_pct = 30;
    for (int i = 0; i < 4; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord());
      wait_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    coord_r_i = '0;
    coord_s_i = '0;
    coord_t_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(70, 0, 0);
    test_random(70, 81, 0);
    test_random(70, 0, 81);
    test_random(70, 11, 11);
    test_backpressure();
    test_paced();
    if (errors == 0) begin
      $display("hex20_shape_and_gradient test passed");
    end else begin
      $display("hex20_shape_and_gradient test failed");
    end
    $finish;
  end

endmodule
